/* hw/rtl/assert_macros.svh */
// Assertion macros used by the port-level checker.
// Include guard only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_NORST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/tbpg_pkg.sv */
// Package for the tile background pixel generator: widths, register codes, palette.
// No dependencies.
`default_nettype none

package tbpg_pkg;

  localparam int ADDR_W         = 14;
  localparam int DATA_W         = 8;
  localparam int COLOR_W        = 4;
  localparam int RGB_W          = 24;
  localparam int PIX_W          = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 8;
  localparam int VRAM_DEPTH_DEF = 16384;
  localparam int SCREEN_WIDTH   = 256;
  localparam int SCREEN_HEIGHT  = 192;
  localparam int TEXT_BORDER_X  = 240;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_TBL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_TBL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATT_TBL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLORS   = 3'd5;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_RENDER = 1'b1;

  function automatic logic [RGB_W-1:0] palette_rgb(input logic [COLOR_W-1:0] idx);
    logic [RGB_W-1:0] rgb;
    case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'h000000;
      4'd2:    rgb = 24'h21C842;
      4'd3:    rgb = 24'h5EDC78;
      4'd4:    rgb = 24'h5455ED;
      4'd5:    rgb = 24'h7D76FC;
      4'd6:    rgb = 24'hD4524D;
      4'd7:    rgb = 24'h42EBF5;
      4'd8:    rgb = 24'hFC5554;
      4'd9:    rgb = 24'hFF7978;
      4'd10:   rgb = 24'hD4C154;
      4'd11:   rgb = 24'hE6CE80;
      4'd12:   rgb = 24'h21B03B;
      4'd13:   rgb = 24'hC95BBA;
      4'd14:   rgb = 24'hCCCCCC;
      4'd15:   rgb = 24'hFFFFFF;
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tbpg_if.sv */
// Valid/ready request channels of the pixel generator: input and result.
// Depends on tbpg_pkg.
`default_nettype none

interface tbpg_in_if;
  import tbpg_pkg::*;
  logic                valid;
  logic                ready;
  logic                action;
  logic [ADDR_W-1:0]   vram_address;
  logic [DATA_W-1:0]   vram_data;
  logic [PIX_W-1:0]    pixel_x;
  logic [PIX_W-1:0]    pixel_y;

  modport source (output valid, action, vram_address, vram_data, pixel_x, pixel_y,
                  input ready);
  modport sink   (input valid, action, vram_address, vram_data, pixel_x, pixel_y,
                  output ready);
endinterface

interface tbpg_out_if;
  import tbpg_pkg::*;
  logic                valid;
  logic                ready;
  logic [COLOR_W-1:0]  color_index;
  logic [RGB_W-1:0]    pixel_rgb;

  modport source (output valid, color_index, pixel_rgb, input ready);
  modport sink   (input valid, color_index, pixel_rgb, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tbpg_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module tbpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hw/rtl/tbpg_agu.sv */
// Shared address unit: 14-bit wrapping base+offset add, or one modulo step by VRAM depth.
// Depends on tbpg_pkg.
`default_nettype none

module tbpg_agu #(
  parameter int VRAM_DEPTH = tbpg_pkg::VRAM_DEPTH_DEF
) (
  input  wire logic                        reduce,
  input  wire logic [tbpg_pkg::ADDR_W-1:0] a,
  input  wire logic [tbpg_pkg::ADDR_W-1:0] b,
  output logic      [tbpg_pkg::ADDR_W-1:0] result,
  output logic                             ge_depth
);
  import tbpg_pkg::*;

  localparam logic [ADDR_W:0] DEPTH_EXT = (ADDR_W+1)'(VRAM_DEPTH);

  logic [ADDR_W-1:0] opnd_b;

  assign ge_depth = {1'b0, a} >= DEPTH_EXT;
  assign opnd_b   = reduce ? (~DEPTH_EXT[ADDR_W-1:0] + ADDR_W'(1)) : b;
  assign result   = a + opnd_b;

endmodule

`default_nettype wire

/* hw/rtl/tile_background_pixel_generator_core.sv */
// Top level of the tile background pixel generator: sequencer, config registers, output.
// Depends on tbpg_pkg, tbpg_if, tbpg_ram, tbpg_agu.
//
//  channel  | dir | handshake     | payload
//  in_req   | in  | valid/ready   | action, vram_address, vram_data, pixel_x, pixel_y
//  out_req  | out | valid/ready   | color_index, pixel_rgb
//  cfg_*    | in  | cfg_we only   | cfg_index, cfg_wdata
//
// A write passes from idle to the modulo check, which repeats once per modulo step of the
// address (none at depth 16384) before the RAM write. A render makes 2 (text, multicolor)
// or 3 (Graphics I/II) VRAM reads, each as address add, modulo check and registered RAM
// read on the single RAM port, then loads the result; off-screen pixels load it at once.
// After reset a clearing pass writes zero to all VRAM_DEPTH entries, one per cycle,
// before in_req.ready rises. A stalled result holds the sequencer in its last state.
`default_nettype none

module tile_background_pixel_generator_core #(
  parameter int VRAM_DEPTH = tbpg_pkg::VRAM_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  tbpg_in_if.sink                              in_req,
  tbpg_out_if.source                           out_req,
  input  wire logic                            cfg_we,
  input  wire logic [tbpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tbpg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tbpg_pkg::*;

  localparam int VRAM_AW = $clog2(VRAM_DEPTH);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_ADDR, ST_REDUCE, ST_WAIT, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MODE_TEXT, MODE_MULTI, MODE_G2, MODE_G1
  } mode_t;

  state_t               state_r, state_nxt;
  mode_t                mode_r, mode_nxt;
  logic [VRAM_AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [1:0]           step_r, step_nxt;
  logic                 is_wr_r, is_wr_nxt;
  logic                 blank_r, blank_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0]   out_color_r, out_color_nxt;
  logic [RGB_W-1:0]     out_rgb_r, out_rgb_nxt;
  logic [ADDR_W-1:0]    addr_r, addr_nxt;
  logic [DATA_W-1:0]    wdata_r, wdata_nxt;
  logic [PIX_W-1:0]     x_r, x_nxt;
  logic [4:0]           row_r, row_nxt;
  logic [2:0]           py_r, py_nxt;
  logic [2:0]           px_r, px_nxt;
  logic [9:0]           text_off_r, text_off_nxt;
  logic [DATA_W-1:0]    name_r, name_nxt;
  logic [DATA_W-1:0]    bits_r, bits_nxt;
  logic [DATA_W-1:0]    clr_r, clr_nxt;
  logic [7:0]           mode_a_r, mode_b_r, name_tbl_r, color_tbl_r, patt_tbl_r, colors_r;

  logic                 in_fire;
  logic                 agu_reduce, agu_ge;
  logic [ADDR_W-1:0]    agu_a, agu_b, agu_res;
  logic                 ram_we;
  logic [VRAM_AW-1:0]   ram_addr;
  logic [DATA_W-1:0]    ram_wdata, ram_rdata;
  logic [15:0]          col_prod;
  logic [5:0]           col;
  logic [1:0]           last_step;
  logic [COLOR_W-1:0]   backdrop, raw_color, final_color;
  mode_t                mode_sel;

  tbpg_agu #(.VRAM_DEPTH(VRAM_DEPTH)) u_agu (
    .reduce   (agu_reduce),
    .a        (agu_a),
    .b        (agu_b),
    .result   (agu_res),
    .ge_depth (agu_ge)
  );

  tbpg_ram #(.WIDTH(DATA_W), .DEPTH(VRAM_DEPTH)) u_vram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign in_fire          = in_req.valid && (state_r == ST_IDLE);
  assign in_req.ready     = (state_r == ST_IDLE);
  assign out_req.valid    = out_valid_r;
  assign out_req.color_index = out_color_r;
  assign out_req.pixel_rgb   = out_rgb_r;

  assign backdrop = colors_r[3:0];

  // x / 6 for x < 240 via reciprocal 171/1024
  assign col_prod = 16'(in_req.pixel_x) * 16'd171;
  assign col      = col_prod[15:10];

  always_comb begin
    if (mode_b_r[4]) begin
      mode_sel = MODE_TEXT;
    end else if (mode_b_r[3]) begin
      mode_sel = MODE_MULTI;
    end else if (mode_a_r[1]) begin
      mode_sel = MODE_G2;
    end else begin
      mode_sel = MODE_G1;
    end
  end

  assign last_step = ((mode_r == MODE_TEXT) || (mode_r == MODE_MULTI)) ? 2'd1 : 2'd2;

  // Operand select for the shared address unit
  always_comb begin
    agu_reduce = (state_r == ST_REDUCE);
    agu_a      = addr_r;
    agu_b      = '0;
    if (state_r == ST_ADDR) begin
      case (step_r)
        2'd0: begin
          agu_a = {name_tbl_r[3:0], 10'd0};
          agu_b = (mode_r == MODE_TEXT) ? ADDR_W'(text_off_r) : ADDR_W'({row_r, x_r[7:3]});
        end
        2'd1: begin
          agu_a = (mode_r == MODE_G2) ? {patt_tbl_r[2], 13'd0} : {patt_tbl_r[2:0], 11'd0};
          case (mode_r)
            MODE_MULTI: agu_b = ADDR_W'({name_r, row_r[1:0], py_r[2]});
            MODE_G2:    agu_b = ADDR_W'({row_r[4:3], name_r, py_r});
            default:    agu_b = ADDR_W'({name_r, py_r});
          endcase
        end
        default: begin
          if (mode_r == MODE_G2) begin
            agu_a = {color_tbl_r[7], 13'd0};
            agu_b = ADDR_W'({row_r[4:3], name_r, py_r});
          end else begin
            agu_a = {color_tbl_r, 6'd0};
            agu_b = ADDR_W'(name_r[7:3]);
          end
        end
      endcase
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = addr_r[VRAM_AW-1:0];
    ram_wdata = wdata_r;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_r;
      ram_wdata = '0;
    end else if (state_r == ST_REDUCE && !agu_ge && is_wr_r) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    if (blank_r) begin
      raw_color = backdrop;
    end else begin
      case (mode_r)
        MODE_TEXT:  raw_color = bits_r[~px_r] ? colors_r[7:4] : backdrop;
        MODE_MULTI: raw_color = x_r[2] ? bits_r[3:0] : bits_r[7:4];
        default:    raw_color = bits_r[~x_r[2:0]] ? clr_r[7:4] : clr_r[3:0];
      endcase
    end
    final_color = (raw_color == '0) ? backdrop : raw_color;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    clr_cnt_nxt   = clr_cnt_r;
    step_nxt      = step_r;
    is_wr_nxt     = is_wr_r;
    blank_nxt     = blank_r;
    out_valid_nxt = out_valid_r;
    out_color_nxt = out_color_r;
    out_rgb_nxt   = out_rgb_r;
    addr_nxt      = addr_r;
    wdata_nxt     = wdata_r;
    x_nxt         = x_r;
    row_nxt       = row_r;
    py_nxt        = py_r;
    px_nxt        = px_r;
    text_off_nxt  = text_off_r;
    name_nxt      = name_r;
    bits_nxt      = bits_r;
    clr_nxt       = clr_r;

    if (out_valid_r && out_req.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + VRAM_AW'(1);
        if (clr_cnt_r == VRAM_AW'(VRAM_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          is_wr_nxt    = (in_req.action == ACT_WRITE);
          addr_nxt     = in_req.vram_address;
          wdata_nxt    = in_req.vram_data;
          x_nxt        = in_req.pixel_x;
          row_nxt      = in_req.pixel_y[7:3];
          py_nxt       = in_req.pixel_y[2:0];
          px_nxt       = 3'(in_req.pixel_x - 8'({col, 2'd0} + {1'b0, col, 1'b0}));
          text_off_nxt = 10'({in_req.pixel_y[7:3], 5'd0}) + 10'({in_req.pixel_y[7:3], 3'd0})
                         + 10'(col);
          mode_nxt     = mode_sel;
          step_nxt     = 2'd0;
          blank_nxt    = (in_req.pixel_y >= PIX_W'(SCREEN_HEIGHT)) ||
                         ((mode_sel == MODE_TEXT) && (in_req.pixel_x >= PIX_W'(TEXT_BORDER_X)));
          if (in_req.action == ACT_WRITE) begin
            state_nxt = ST_REDUCE;
          end else if (blank_nxt) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_ADDR;
          end
        end
      end
      ST_ADDR: begin
        addr_nxt  = agu_res;
        state_nxt = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (agu_ge) begin
          addr_nxt = agu_res;
        end else if (is_wr_r) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        case (step_r)
          2'd0:    name_nxt = ram_rdata;
          2'd1:    bits_nxt = ram_rdata;
          default: clr_nxt  = ram_rdata;
        endcase
        if (step_r == last_step) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt  = step_r + 2'd1;
          state_nxt = ST_ADDR;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_req.ready) begin
          out_valid_nxt = 1'b1;
          out_color_nxt = final_color;
          out_rgb_nxt   = palette_rgb(final_color);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    step_r      <= step_nxt;
    is_wr_r     <= is_wr_nxt;
    blank_r     <= blank_nxt;
    out_color_r <= out_color_nxt;
    out_rgb_r   <= out_rgb_nxt;
    addr_r      <= addr_nxt;
    wdata_r     <= wdata_nxt;
    x_r         <= x_nxt;
    row_r       <= row_nxt;
    py_r        <= py_nxt;
    px_r        <= px_nxt;
    text_off_r  <= text_off_nxt;
    name_r      <= name_nxt;
    bits_r      <= bits_nxt;
    clr_r       <= clr_nxt;
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      mode_a_r    <= '0;
      mode_b_r    <= '0;
      name_tbl_r  <= '0;
      color_tbl_r <= '0;
      patt_tbl_r  <= '0;
      colors_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE_A:    mode_a_r    <= cfg_wdata;
          CFG_MODE_B:    mode_b_r    <= cfg_wdata;
          CFG_NAME_TBL:  name_tbl_r  <= cfg_wdata;
          CFG_COLOR_TBL: color_tbl_r <= cfg_wdata;
          CFG_PATT_TBL:  patt_tbl_r  <= cfg_wdata;
          CFG_COLORS:    colors_r    <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tbpg_checker.sv */
// Port-level checker for the pixel generator core, bound to the top level.
// Depends on tbpg_pkg, assert_macros.svh, tile_background_pixel_generator_core.
`default_nettype none
`include "assert_macros.svh"

module tbpg_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [tbpg_pkg::COLOR_W-1:0]   out_color_index,
  input wire logic [tbpg_pkg::RGB_W-1:0]     out_pixel_rgb
);
  import tbpg_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `ASSERT_IMPL(a_rgb_matches, clk, rst_n, out_valid, out_pixel_rgb == palette_rgb(out_color_index))
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready && !$rose(out_valid))
  `ASSERT_NEXT_NORST(a_reset_quiet, clk, !rst_n, !out_valid && !in_ready)

endmodule

bind tile_background_pixel_generator_core tbpg_checker u_tbpg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .out_valid       (out_req.valid),
  .out_ready       (out_req.ready),
  .out_color_index (out_req.color_index),
  .out_pixel_rgb   (out_req.pixel_rgb)
);

`default_nettype wire

/* tb/tbpg_checker.sv */
// Scoreboard for the tile background pixel generator: keeps its own VRAM image and
// mode registers, predicts the color of every render request and checks the results.
// Depends on tbpg_pkg.
module tbpg_scoreboard #(
  parameter int VRAM_DEPTH = tbpg_pkg::VRAM_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               in_action,
  input  logic [tbpg_pkg::ADDR_W-1:0]        in_vram_address,
  input  logic [tbpg_pkg::DATA_W-1:0]        in_vram_data,
  input  logic [tbpg_pkg::PIX_W-1:0]         in_pixel_x,
  input  logic [tbpg_pkg::PIX_W-1:0]         in_pixel_y,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [tbpg_pkg::COLOR_W-1:0]       out_color_index,
  input  logic [tbpg_pkg::RGB_W-1:0]         out_pixel_rgb,
  input  logic                               cfg_we,
  input  logic [tbpg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tbpg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output int                                 fail_count,
  output int                                 pending
);
  import tbpg_pkg::*;

  typedef struct packed {
    logic [COLOR_W-1:0] color_index;
    logic [RGB_W-1:0]   rgb;
  } pixel_t;

  localparam logic [RGB_W-1:0] PALETTE [16] = '{
    24'h000000, 24'h000000, 24'h21C842, 24'h5EDC78,
    24'h5455ED, 24'h7D76FC, 24'hD4524D, 24'h42EBF5,
    24'hFC5554, 24'hFF7978, 24'hD4C154, 24'hE6CE80,
    24'h21B03B, 24'hC95BBA, 24'hCCCCCC, 24'hFFFFFF
  };

  logic [DATA_W-1:0] vram [VRAM_DEPTH];
  logic [7:0] mode_a, mode_b, name_tbl, color_tbl, patt_tbl, colors;
  pixel_t expected_pixels [$];
  int errs = 0;

  function automatic int unsigned vram_byte(int unsigned addr);
    return {24'd0, vram[(addr & 32'h3FFF) % VRAM_DEPTH]};
  endfunction

  // Color of an on-screen pixel before backdrop substitution.
  function automatic logic [3:0] tile_color(int unsigned x, int unsigned y);
    int unsigned nt_origin, pt_origin, row, py, px, name, bits, clr, idx, pb, cb;
    nt_origin = 32'(name_tbl[3:0]) * 1024;
    pt_origin = 32'(patt_tbl[2:0]) * 2048;
    row = y / 8;
    py = y % 8;
    if (mode_b[4]) begin
      if (x >= TEXT_BORDER_X) return colors[3:0];
      px = x % 6;
      name = vram_byte(nt_origin + row * 40 + x / 6);
      bits = vram_byte(pt_origin + name * 8 + py);
      return bits[7 - px] ? colors[7:4] : colors[3:0];
    end
    name = vram_byte(nt_origin + row * 32 + x / 8);
    if (mode_b[3]) begin
      bits = vram_byte(pt_origin + name * 8 + (row % 4) * 2 + py / 4);
      return (x % 8 < 4) ? bits[7:4] : bits[3:0];
    end
    if (mode_a[1]) begin
      pb = patt_tbl[2] ? 32'h2000 : 32'h0;
      cb = color_tbl[7] ? 32'h2000 : 32'h0;
      idx = ((row / 8) * 256 + name) * 8 + py;
      bits = vram_byte(pb + idx);
      clr = vram_byte(cb + idx);
    end else begin
      bits = vram_byte(pt_origin + name * 8 + py);
      clr = vram_byte(32'(color_tbl) * 64 + name / 8);
    end
    return bits[7 - (x % 8)] ? clr[7:4] : clr[3:0];
  endfunction

  function automatic pixel_t predict_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
    pixel_t p;
    logic [3:0] c;
    if (32'(y) >= SCREEN_HEIGHT) c = colors[3:0];
    else c = tile_color(32'(x), 32'(y));
    if (c == 4'd0) c = colors[3:0];
    p.color_index = c;
    p.rgb = PALETTE[c];
    return p;
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      foreach (vram[i]) vram[i] = '0;
      mode_a = '0;
      mode_b = '0;
      name_tbl = '0;
      color_tbl = '0;
      patt_tbl = '0;
      colors = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE_A:    mode_a = cfg_wdata;
          CFG_MODE_B:    mode_b = cfg_wdata;
          CFG_NAME_TBL:  name_tbl = cfg_wdata;
          CFG_COLOR_TBL: color_tbl = cfg_wdata;
          CFG_PATT_TBL:  patt_tbl = cfg_wdata;
          CFG_COLORS:    colors = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel result with no render request pending");
          errs++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_color_index !== want.color_index) begin
            $error("color_index: expected %0d, actual %0d", want.color_index, out_color_index);
            errs++;
          end
          if (out_pixel_rgb !== want.rgb) begin
            $error("pixel_rgb: expected %06h, actual %06h", want.rgb, out_pixel_rgb);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_action == ACT_WRITE)
          vram[(32'(in_vram_address) & 32'h3FFF) % VRAM_DEPTH] = in_vram_data;
        else
          expected_pixels.push_back(predict_pixel(in_pixel_x, in_pixel_y));
      end
    end
    fail_count <= errs;
    pending <= expected_pixels.size();
  end

endmodule

/* tb/tb.sv */
// Top of the pixel generator testbench: clock, reset, VRAM fill and render requests,
// register settings per phase, random stalls on both channels, and the verdict.
// Depends on tbpg_pkg, tbpg_if, the core and tbpg_scoreboard.
module tb;
  import tbpg_pkg::*;

  typedef enum logic [1:0] {MODE_TEXT, MODE_MULTI, MODE_G2, MODE_G1} bg_mode_t;

  localparam int unsigned SRC_IDLE [3]  = '{27, 87, 0};
  localparam int unsigned SINK_IDLE [3] = '{87, 27, 0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int writes_sent = 0;
  int renders_sent = 0;
  int settings_used = 0;
  int fail_count, pending;
  logic [7:0] reg_mode_a = '0, reg_mode_b = '0, reg_name = '0;
  logic [7:0] reg_color = '0, reg_patt = '0, reg_colors = '0;

  tbpg_in_if  in_ch ();
  tbpg_out_if out_ch ();

  tile_background_pixel_generator_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch),
    .out_req   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tbpg_scoreboard #(.VRAM_DEPTH(VRAM_DEPTH_DEF)) pixel_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_action       (in_ch.action),
    .in_vram_address (in_ch.vram_address),
    .in_vram_data    (in_ch.vram_data),
    .in_pixel_x      (in_ch.pixel_x),
    .in_pixel_y      (in_ch.pixel_y),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_color_index (out_ch.color_index),
    .out_pixel_rgb   (out_ch.pixel_rgb),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send(input logic act, input logic [ADDR_W-1:0] addr,
                      input logic [DATA_W-1:0] data, input logic [PIX_W-1:0] px,
                      input logic [PIX_W-1:0] py);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.vram_address <= addr;
    in_ch.vram_data <= data;
    in_ch.pixel_x <= px;
    in_ch.pixel_y <= py;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (act == ACT_WRITE) writes_sent++;
    else renders_sent++;
  endtask

  // Wait out every pending result, then let trailing writes finish.
  task automatic drain(input int settle);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [7:0] a, b, nt, ct, pt, co);
    cfg_put(CFG_MODE_A, a);
    cfg_put(CFG_MODE_B, b);
    cfg_put(CFG_NAME_TBL, nt);
    cfg_put(CFG_COLOR_TBL, ct);
    cfg_put(CFG_PATT_TBL, pt);
    cfg_put(CFG_COLORS, co);
    cfg_we <= 1'b0;
    reg_mode_a = a;
    reg_mode_b = b;
    reg_name = nt;
    reg_color = ct;
    reg_patt = pt;
    reg_colors = co;
    settings_used++;
  endtask

  task automatic pick_regs(input bg_mode_t m);
    logic [7:0] a, b;
    a = 8'($urandom);
    b = 8'($urandom);
    case (m)
      MODE_TEXT:  b[4] = 1'b1;
      MODE_MULTI: begin
        b[4] = 1'b0;
        b[3] = 1'b1;
      end
      MODE_G2: begin
        b[4:3] = 2'b00;
        a[1] = 1'b1;
      end
      default: begin
        b[4:3] = 2'b00;
        a[1] = 1'b0;
      end
    endcase
    load_regs(a, b, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Fill the name, pattern and color bytes behind one tile row, then render in it.
  task automatic tile_burst();
    logic [7:0] x, y, nm, x0;
    int unsigned row, py, na, pa, ca, idx, span;
    logic has_color;
    x = 8'($urandom);
    y = 8'($urandom_range(SCREEN_HEIGHT - 1));
    nm = 8'($urandom);
    row = 32'(y) / 8;
    py = 32'(y) % 8;
    has_color = 1'b0;
    ca = 0;
    if (reg_mode_b[4]) begin
      if (32'(x) >= TEXT_BORDER_X && $urandom_range(3) != 0)
        x = 8'($urandom_range(TEXT_BORDER_X - 1));
      na = 32'(reg_name[3:0]) * 1024 + row * 40 + 32'(x) / 6;
      pa = 32'(reg_patt[2:0]) * 2048 + 32'(nm) * 8 + py;
      x0 = x - x % 6;
      span = 6;
    end else begin
      na = 32'(reg_name[3:0]) * 1024 + row * 32 + 32'(x) / 8;
      x0 = {x[7:3], 3'b000};
      span = 8;
      if (reg_mode_b[3]) begin
        pa = 32'(reg_patt[2:0]) * 2048 + 32'(nm) * 8 + (row % 4) * 2 + py / 4;
      end else if (reg_mode_a[1]) begin
        idx = ((row / 8) * 256 + 32'(nm)) * 8 + py;
        pa = (reg_patt[2] ? 32'h2000 : 32'h0) + idx;
        ca = (reg_color[7] ? 32'h2000 : 32'h0) + idx;
        has_color = 1'b1;
      end else begin
        pa = 32'(reg_patt[2:0]) * 2048 + 32'(nm) * 8 + py;
        ca = 32'(reg_color) * 64 + 32'(nm) / 8;
        has_color = 1'b1;
      end
    end
    if ($urandom_range(9) != 0) send(ACT_WRITE, 14'(na), nm, 8'($urandom), 8'($urandom));
    if ($urandom_range(9) != 0)
      send(ACT_WRITE, 14'(pa), 8'($urandom), 8'($urandom), 8'($urandom));
    if (has_color && $urandom_range(9) != 0)
      send(ACT_WRITE, 14'(ca), 8'($urandom), 8'($urandom), 8'($urandom));
    repeat ($urandom_range(4, 1))
      send(ACT_RENDER, 14'($urandom), 8'($urandom), x0 + 8'($urandom_range(span - 1)), y);
  endtask

  task automatic run_segment(input int count);
    int start;
    int unsigned r;
    start = writes_sent + renders_sent;
    while (writes_sent + renders_sent - start < count) begin
      r = $urandom_range(99);
      if (r < 70)
        tile_burst();
      else if (r < 85)
        send(ACT_WRITE, 14'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      else
        send(ACT_RENDER, 14'($urandom), 8'($urandom), 8'($urandom),
             ($urandom_range(3) == 0) ? 8'($urandom_range(255, SCREEN_HEIGHT))
                                      : 8'($urandom_range(SCREEN_HEIGHT - 1)));
    end
  endtask

  initial begin
    int seg;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_WRITE;
    in_ch.vram_address = '0;
    in_ch.vram_data = '0;
    in_ch.pixel_x = '0;
    in_ch.pixel_y = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: Graphics I, all tables at 0, backdrop 0
    send(ACT_WRITE, 14'h3FFF, 8'hFF, 8'h00, 8'h00);
    send(ACT_WRITE, 14'h0000, 8'h81, 8'hFF, 8'hFF);
    send(ACT_WRITE, 14'd1032, 8'hF0, 8'h00, 8'h00);
    send(ACT_WRITE, 14'd16, 8'h70, 8'h00, 8'h00);
    send(ACT_RENDER, 14'h3FFF, 8'hFF, 8'd0, 8'd0);
    send(ACT_RENDER, 14'h0000, 8'h00, 8'd4, 8'd0);
    send(ACT_RENDER, 14'h0000, 8'h00, 8'd255, 8'd191);
    send(ACT_RENDER, 14'h0000, 8'h00, 8'd0, 8'd191);
    send(ACT_RENDER, 14'h0000, 8'h00, 8'd255, 8'd192);
    send(ACT_RENDER, 14'h0000, 8'h00, 8'd0, 8'd255);
    drain(16);

    // text mode with highest table bases
    load_regs(8'h00, 8'h10, 8'h0F, 8'h00, 8'h07, 8'hF4);
    send(ACT_WRITE, 14'd15399, 8'hFF, 8'h00, 8'h00);
    send(ACT_WRITE, 14'd16376, 8'h04, 8'h00, 8'h00);
    send(ACT_RENDER, 14'h0000, 8'h00, 8'd239, 8'd0);
    send(ACT_RENDER, 14'h0000, 8'h00, 8'd238, 8'd0);
    send(ACT_RENDER, 14'h0000, 8'h00, 8'd240, 8'd0);
    send(ACT_RENDER, 14'h0000, 8'h00, 8'd255, 8'd7);
    send(ACT_RENDER, 14'h0000, 8'h00, 8'd0, 8'd200);
    send(ACT_RENDER, 14'h0000, 8'h00, 8'd6, 8'd191);

    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < 3; k++) begin
        seg = p * 3 + k;
        drain(16);
        if (seg == 0)
          load_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        else if (seg == 1)
          load_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        else
          pick_regs(bg_mode_t'(seg % 4));
        src_idle_pct = SRC_IDLE[p];
        sink_idle_pct = SINK_IDLE[p];
        run_segment(143);
      end
    end
    drain(16);

    $display("Run covered %0d VRAM writes and %0d pixel renders over %0d register settings,",
             writes_sent, renders_sent, settings_used);
    $display("text, multicolor and both graphics modes, with stalls on either channel.");
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
